### src/waypoint_velocity_profiler_assert.svh
// ----------------------------------------------------------------------------
// Waypoint velocity profiler assertion macros
// Shared assertion wrappers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef WAYPOINT_VELOCITY_PROFILER_ASSERT_SVH
`define WAYPOINT_VELOCITY_PROFILER_ASSERT_SVH

`ifndef SYNTHESIS
// condition holds at every clock edge outside reset
`define WVP_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("wvp assertion failed");
// consequence holds in the cycle after the antecedent
`define WVP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wvp assertion failed");
`else
`define WVP_ASSERT(lbl, cond)
`define WVP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### src/wvp_pkg.sv
// ----------------------------------------------------------------------------
// Waypoint velocity profiler package
// Types, constants and helper functions shared by the profiler modules.
// ----------------------------------------------------------------------------
package wvp_pkg;

    localparam int unsigned ROUTE_DEPTH_DEF = 16;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIN_ACC      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_ACC      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_MARGIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MARGIN = 3'd4;

    localparam logic [16:0] TICK_PERIOD_RST  = 17'd655;
    localparam logic [19:0] LIN_ACC_RST      = 20'd32768;
    localparam logic [19:0] ANG_ACC_RST      = 20'd104858;
    localparam logic [16:0] DIST_MARGIN_RST  = 17'd1311;
    localparam logic [16:0] ANGLE_MARGIN_RST = 17'd1144;

    localparam logic [31:0] STAY_FOREVER = 32'hFFFF_FFFF;
    localparam logic [30:0] DIST_MAX     = 31'h7FFF_FFFF;

    // stream payload widths
    localparam int unsigned S_TDATA_W = 296;
    localparam int unsigned M_TDATA_W = 136;
    localparam int unsigned M_TUSER_W = 2;

    // divider width (twice the largest acceleration limit)
    localparam int unsigned DIV_W = 21;

    typedef enum logic [1:0] {
        DM_POS   = 2'd0,
        DM_SPEED = 2'd1,
        DM_WAIT  = 2'd2
    } t_drive;

    typedef enum logic [1:0] {
        MOT_STILL = 2'd0,
        MOT_ROT   = 2'd1,
        MOT_LIN   = 2'd2,
        MOT_CURVE = 2'd3
    } t_motion;

    typedef enum logic [1:0] {
        ALU_MUL  = 2'd0,
        ALU_DIV  = 2'd1,
        ALU_SQRT = 2'd2
    } t_alu_op;

    // tick sequencer states
    typedef enum logic [4:0] {
        S_IDLE, S_RD_NEXT, S_RD_CUR, S_CAPT, S_MEAS, S_SQY, S_SQRT, S_DIST,
        S_DECIDE, S_T1, S_T2, S_T3, S_T4, S_RAMP, S_UPD, S_POS, S_WAIT,
        S_OUT, S_AW
    } t_state;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] spd;
        logic [31:0] trn;
        logic [31:0] heading;
        logic [31:0] stay;
        logic [1:0]  kind;
    } t_route_entry;

    // clamp a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] res;
        if (v > 34'sh0_7FFF_FFFF) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

### src/wvp_route_mem.sv
// ----------------------------------------------------------------------------
// Waypoint route memory
// Single write port, single registered read port holding the waypoint queue.
// ----------------------------------------------------------------------------
module wvp_route_mem #(
    parameter int unsigned DEPTH = wvp_pkg::ROUTE_DEPTH_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  wvp_pkg::t_route_entry i_wdata,
    input  logic                  i_re,
    input  logic [AW-1:0]         i_raddr,
    output wvp_pkg::t_route_entry o_rdata
);
    import wvp_pkg::*;

    t_route_entry r_mem [DEPTH];
    t_route_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/wvp_serial_alu.sv
// ----------------------------------------------------------------------------
// Waypoint profiler serial arithmetic unit
// Bit-serial multiply (32x32), restoring divide (64/21) and square root (64).
// ----------------------------------------------------------------------------
module wvp_serial_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wvp_pkg::t_alu_req i_req,
    input  logic [63:0]       i_a,
    input  logic [31:0]       i_b,
    output logic              o_busy,
    output logic              o_done,
    output logic [63:0]       o_res
);
    `include "waypoint_velocity_profiler_assert.svh"
    import wvp_pkg::*;

    t_alu_op     r_op;
    logic        r_busy;
    logic        r_done;
    logic [6:0]  r_cnt;
    logic [34:0] r_hi;
    logic [63:0] r_lo;
    logic [31:0] r_b;
    logic [31:0] r_root;

    logic [32:0] mul_t;
    logic [21:0] div_sh;
    logic        div_ge;
    logic [21:0] div_rem;
    logic [34:0] sq_sh;
    logic [34:0] sq_tr;
    logic        sq_ge;

    // one step of each operation
    always_comb begin
        mul_t   = {1'b0, r_hi[31:0]} + (r_lo[0] ? {1'b0, r_b} : 33'd0);
        div_sh  = {r_hi[20:0], r_lo[63]};
        div_ge  = div_sh >= {1'b0, r_b[DIV_W-1:0]};
        div_rem = div_sh - {1'b0, r_b[DIV_W-1:0]};
        sq_sh   = {r_hi[32:0], r_lo[63:62]};
        sq_tr   = {1'b0, r_root, 2'b01};
        sq_ge   = sq_sh >= sq_tr;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_req.op == ALU_DIV) ? 7'd64 : 7'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op   <= i_req.op;
            r_hi   <= '0;
            r_lo   <= i_a;
            r_b    <= i_b;
            r_root <= '0;
        end else if (r_busy) begin
            case (r_op)
                ALU_MUL: begin
                    r_hi <= {3'b000, mul_t[32:1]};
                    r_lo <= {r_lo[63:32], mul_t[0], r_lo[31:1]};
                end
                ALU_DIV: begin
                    r_hi <= div_ge ? {14'd0, div_rem[20:0]} : {14'd0, div_sh[20:0]};
                    r_lo <= {r_lo[62:0], div_ge};
                end
                ALU_SQRT: begin
                    r_hi   <= sq_ge ? (sq_sh - sq_tr) : sq_sh;
                    r_root <= {r_root[30:0], sq_ge};
                    r_lo   <= {r_lo[61:0], 2'b00};
                end
                default: begin
                    r_hi <= r_hi;
                end
            endcase
        end
    end

    // result select
    always_comb begin
        case (r_op)
            ALU_MUL:  o_res = {r_hi[31:0], r_lo[31:0]};
            ALU_DIV:  o_res = r_lo;
            ALU_SQRT: o_res = {32'd0, r_root};
            default:  o_res = '0;
        endcase
    end

    assign o_busy = r_busy;
    assign o_done = r_done;

    `WVP_ASSERT(a_alu_no_restart, !(i_req.start && r_busy))
    `WVP_ASSERT_NEXT(a_alu_done_idle, r_done, !r_busy && !r_done)
    `WVP_ASSERT(a_alu_cnt_live, !r_busy || r_cnt != 7'd0)
endmodule

### src/waypoint_velocity_profiler.sv
// ----------------------------------------------------------------------------
// Waypoint velocity profiler
// Waypoint queue plus tick sequencer for speed ramps and position targets.
//
//   channel  | dir | handshake             | payload
//   ---------+-----+-----------------------+---------------------------------
//   s_axis   | in  | s_tvalid / s_tready   | s_tuser func, s_tdata odo + wp
//   m_axis   | out | m_tvalid / m_tready   | m_tuser valids, m_tdata result
//   cfg      | in  | i_cfg_we              | i_cfg_idx, i_cfg_wdata
//
// A push goes from idle straight to the output state. A tick runs on one
// shared bit-serial unit that does every multiply and the root (32 steps
// each) and the divides (64 steps each); a full speed ramp uses five
// multiplies, a root and two divides. Reset is synchronous and needs no
// clearing pass; the queue is only read where written. Input is taken only
// between items; a stalled output holds the sequencer in its final state.
// ----------------------------------------------------------------------------
module waypoint_velocity_profiler #(
    parameter int unsigned ROUTE_DEPTH = wvp_pkg::ROUTE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // in: [0] func
    input  logic                           s_tuser,
    // in: odo_x, odo_y, odo_angle, target_reached, wp_x, wp_y, wp_speed,
    //     wp_turn_speed, wp_heading, wp_stay, wp_motion, zero pad
    input  logic [wvp_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // out: [0] speed_valid, [1] pos_valid
    output logic [wvp_pkg::M_TUSER_W-1:0]  m_tuser,
    // out: cmd_v_lin, cmd_v_ang, target_dist, target_turn, drive_mode_out,
    //      push_status, zero pad
    output logic [wvp_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           i_cfg_we,
    input  logic [wvp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wvp_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    `include "waypoint_velocity_profiler_assert.svh"
    import wvp_pkg::*;

    localparam int unsigned AW = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(ROUTE_DEPTH + 1);
    localparam int unsigned SW = AW + 1;

    t_state r_state, n_state;
    t_state r_ret;

    // configuration
    logic [16:0] r_tick_period;
    logic [19:0] r_lin_acc;
    logic [19:0] r_ang_acc;
    logic [16:0] r_dist_margin;
    logic [16:0] r_angle_margin;

    // control state
    logic [AW-1:0]      r_head;
    logic [CW-1:0]      r_count;
    logic signed [31:0] r_lin_speed;
    logic signed [31:0] r_ang_speed;
    t_drive             r_drive;
    t_motion            r_motion;
    logic [31:0]        r_wait_left;

    // tick operands and captured entries
    logic [31:0]        r_odo_x, r_odo_y, r_odo_a;
    logic               r_reached;
    logic [31:0]        r_nx, r_ny, r_nhead, r_nl, r_na;
    logic [1:0]         r_nkind;
    logic [31:0]        r_cl, r_ca, r_cstay;

    // measurement and trigger work registers
    logic [31:0]        r_ay;
    logic [31:0]        r_absturn;
    logic signed [31:0] r_turn;
    logic               r_inang;
    logic [63:0]        r_a2;
    logic [30:0]        r_dist;
    logic signed [31:0] r_g, r_v, r_c;
    logic [19:0]        r_lim;
    logic               r_sgn;
    logic [32:0]        r_d;
    logic [31:0]        r_m;
    logic [31:0]        r_x;
    logic [63:0]        r_t1;
    logic               r_hit;
    logic               r_dneg;

    // result under construction
    logic               r_res_spd, r_res_pos, r_res_push;
    logic [31:0]        r_res_vlin, r_res_vang, r_res_turn;
    logic [30:0]        r_res_dist;

    // output register
    logic                 r_m_valid;
    logic [M_TUSER_W-1:0] r_m_tuser;
    logic [M_TDATA_W-1:0] r_m_tdata;

    // arithmetic unit and memory hookup
    t_alu_req     alu_req;
    logic [63:0]  alu_a;
    logic [31:0]  alu_b;
    logic         alu_busy, alu_done;
    logic [63:0]  alu_res;
    logic         mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    t_route_entry mem_wdata, mem_rdata;

    // helpers
    logic          s_acc, out_free, full, tick_active;
    logic [AW-1:0] slot1;
    logic [SW-1:0] wsum;
    logic [32:0]   dx, dy, da;
    logic [31:0]   adx, ady, ada;
    logic [64:0]   sqsum;
    logic          inm;
    logic          trig_mode;
    logic signed [31:0] tg, tv, tc;
    logic [19:0]   tlim;
    logic [32:0]   td;
    logic [31:0]   tm;
    logic [19:0]   aeff;
    logic          tneg, thit;
    logic signed [31:0] goal;
    logic [32:0]   d2;
    logic [31:0]   mag2;
    logic [19:0]   m2;
    logic [20:0]   step;
    logic signed [33:0] nv;
    logic [31:0]   g_abs;

    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !r_m_valid || m_tready;
    assign full     = r_count >= CW'(ROUTE_DEPTH);
    assign tick_active = (r_count >= CW'(2)) &&
                         ((r_drive == DM_SPEED) || (r_drive == DM_POS));

    // datapath helpers
    always_comb begin
        slot1 = (r_head == AW'(ROUTE_DEPTH - 1)) ? '0 : r_head + AW'(1);
        wsum  = SW'(r_head) + SW'(r_count);
        if (wsum >= SW'(ROUTE_DEPTH)) begin
            mem_waddr = AW'(wsum - SW'(ROUTE_DEPTH));
        end else begin
            mem_waddr = AW'(wsum);
        end

        dx  = {r_nx[31], r_nx} - {r_odo_x[31], r_odo_x};
        dy  = {r_ny[31], r_ny} - {r_odo_y[31], r_odo_y};
        da  = {r_nhead[31], r_nhead} - {r_odo_a[31], r_odo_a};
        adx = dx[32] ? 32'(~dx + 33'd1) : dx[31:0];
        ady = dy[32] ? 32'(~dy + 33'd1) : dy[31:0];
        ada = da[32] ? 32'(~da + 33'd1) : da[31:0];

        sqsum = {1'b0, r_a2} + {1'b0, alu_res};
        inm   = r_inang && ({1'b0, r_dist} <= {15'd0, r_dist_margin});

        // trigger operands by motion kind
        trig_mode = (r_motion == MOT_LIN) || (r_motion == MOT_ROT);
        if (r_motion == MOT_ROT) begin
            tg = signed'(r_na); tv = r_ang_speed; tc = signed'(r_ca); tlim = r_ang_acc;
        end else begin
            tg = signed'(r_nl); tv = r_lin_speed; tc = signed'(r_cl); tlim = r_lin_acc;
        end
        td = {tg[31], tg} - {tv[31], tv};
        tm = td[32] ? 32'(~td + 33'd1) : td[31:0];
        aeff  = (r_lim == 20'd0) ? 20'd1 : r_lim;
        g_abs = r_g[31] ? 32'(~{1'b1, r_g} + 33'd1) : r_g;

        // trigger compare: x <= t1 -/+ t2
        tneg = r_g[31] ^ (r_sgn & r_d[32]);
        if (tneg) begin
            thit = ({33'd0, r_x} + {1'b0, alu_res}) <= {1'b0, r_t1};
        end else begin
            thit = {33'd0, r_x} <= ({1'b0, r_t1} + {1'b0, alu_res});
        end

        // ramp step
        goal = r_hit ? r_g : r_c;
        d2   = {goal[31], goal} - {r_v[31], r_v};
        mag2 = d2[32] ? 32'(~d2 + 33'd1) : d2[31:0];
        m2   = (mag2 > {12'd0, r_lim}) ? r_lim : mag2[19:0];
        step = alu_res[36:16];
        if (r_dneg) begin
            nv = {{2{r_v[31]}}, r_v} - {13'd0, step};
        end else begin
            nv = {{2{r_v[31]}}, r_v} + {13'd0, step};
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    if (s_tuser) begin
                        n_state = S_OUT;
                    end else if (tick_active) begin
                        n_state = S_RD_NEXT;
                    end else begin
                        n_state = S_WAIT;
                    end
                end
            end
            S_RD_NEXT: n_state = S_RD_CUR;
            S_RD_CUR:  n_state = S_CAPT;
            S_CAPT:    n_state = (r_drive == DM_SPEED) ? S_MEAS : S_POS;
            S_MEAS:    n_state = S_AW;
            S_SQY:     n_state = S_AW;
            S_SQRT:    n_state = sqsum[64] ? S_DECIDE : S_AW;
            S_DIST:    n_state = S_DECIDE;
            S_DECIDE: begin
                if (inm || !trig_mode) begin
                    n_state = S_POS;
                end else begin
                    n_state = S_AW;
                end
            end
            S_T1:   n_state = S_AW;
            S_T2:   n_state = S_AW;
            S_T3:   n_state = S_AW;
            S_T4:   n_state = S_RAMP;
            S_RAMP: n_state = S_AW;
            S_UPD:  n_state = S_POS;
            S_POS:  n_state = S_WAIT;
            S_WAIT: n_state = S_OUT;
            S_OUT:  n_state = out_free ? S_IDLE : S_OUT;
            S_AW:   n_state = alu_done ? r_ret : S_AW;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs: handshake, memory reads, arithmetic launches
    always_comb begin
        s_tready      = (r_state == S_IDLE);
        mem_re        = 1'b0;
        mem_raddr     = r_head;
        alu_req.start = 1'b0;
        alu_req.op    = ALU_MUL;
        alu_a         = '0;
        alu_b         = '0;
        case (r_state)
            S_RD_NEXT: begin
                mem_re    = 1'b1;
                mem_raddr = slot1;
            end
            S_RD_CUR: begin
                mem_re = 1'b1;
            end
            S_MEAS: begin
                alu_req.start = 1'b1;
                alu_a = {32'd0, adx};
                alu_b = adx;
            end
            S_SQY: begin
                alu_req.start = 1'b1;
                alu_a = {32'd0, r_ay};
                alu_b = r_ay;
            end
            S_SQRT: begin
                alu_req.start = !sqsum[64];
                alu_req.op    = ALU_SQRT;
                alu_a = sqsum[63:0];
            end
            S_DECIDE: begin
                alu_req.start = !inm && trig_mode;
                alu_a = {32'd0, tm};
                alu_b = tm;
            end
            S_T1: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_DIV;
                alu_a = alu_res;
                alu_b = {11'd0, aeff, 1'b0};
            end
            S_T2: begin
                alu_req.start = 1'b1;
                alu_a = {32'd0, g_abs};
                alu_b = r_m;
            end
            S_T3: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_DIV;
                alu_a = alu_res;
                alu_b = {12'd0, aeff};
            end
            S_RAMP: begin
                alu_req.start = 1'b1;
                alu_a = {44'd0, m2};
                alu_b = {15'd0, r_tick_period};
            end
            default: begin
                alu_req.start = 1'b0;
            end
        endcase
    end

    // push write
    assign mem_we    = s_acc && s_tuser && !full;
    assign mem_wdata = '{x: s_tdata[128:97], y: s_tdata[160:129], spd: s_tdata[192:161],
                         trn: s_tdata[224:193], heading: s_tdata[256:225],
                         stay: s_tdata[288:257], kind: s_tdata[290:289]};

    // state register and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_ret          <= S_IDLE;
            r_tick_period  <= TICK_PERIOD_RST;
            r_lin_acc      <= LIN_ACC_RST;
            r_ang_acc      <= ANG_ACC_RST;
            r_dist_margin  <= DIST_MARGIN_RST;
            r_angle_margin <= ANGLE_MARGIN_RST;
            r_head         <= '0;
            r_count        <= '0;
            r_lin_speed    <= '0;
            r_ang_speed    <= '0;
            r_drive        <= DM_SPEED;
            r_motion       <= MOT_LIN;
            r_wait_left    <= '0;
            r_m_valid      <= 1'b0;
        end else begin
            r_state <= n_state;

            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TICK_PERIOD:  r_tick_period  <= i_cfg_wdata[16:0];
                    CFG_LIN_ACC:      r_lin_acc      <= i_cfg_wdata;
                    CFG_ANG_ACC:      r_ang_acc      <= i_cfg_wdata;
                    CFG_DIST_MARGIN:  r_dist_margin  <= i_cfg_wdata[16:0];
                    CFG_ANGLE_MARGIN: r_angle_margin <= i_cfg_wdata[16:0];
                    default: begin
                        r_tick_period <= r_tick_period;
                    end
                endcase
            end

            if (mem_we) begin
                r_count <= r_count + CW'(1);
            end

            // return point after an arithmetic launch
            case (r_state)
                S_MEAS:   r_ret <= S_SQY;
                S_SQY:    r_ret <= S_SQRT;
                S_SQRT:   r_ret <= S_DIST;
                S_DECIDE: r_ret <= S_T1;
                S_T1:     r_ret <= S_T2;
                S_T2:     r_ret <= S_T3;
                S_T3:     r_ret <= S_T4;
                S_RAMP:   r_ret <= S_UPD;
                default:  r_ret <= r_ret;
            endcase

            // mode transitions and speed updates
            case (r_state)
                S_DECIDE: begin
                    if (inm) begin
                        r_drive <= DM_POS;
                    end else if (r_motion == MOT_STILL) begin
                        r_lin_speed <= '0;
                        r_ang_speed <= '0;
                    end
                end
                S_UPD: begin
                    if (r_motion == MOT_LIN) begin
                        r_lin_speed <= sat32(nv);
                        r_ang_speed <= '0;
                    end else begin
                        r_ang_speed <= sat32(nv);
                        r_lin_speed <= '0;
                    end
                end
                S_POS: begin
                    if (r_drive == DM_POS && r_count >= CW'(2) && r_reached) begin
                        if (r_cstay > {15'd0, r_tick_period}) begin
                            r_drive     <= DM_WAIT;
                            r_wait_left <= (r_cstay == STAY_FOREVER) ? STAY_FOREVER :
                                           r_cstay - {15'd0, r_tick_period};
                        end else begin
                            r_drive <= DM_SPEED;
                        end
                        r_lin_speed <= '0;
                        r_ang_speed <= '0;
                        r_head      <= slot1;
                        r_count     <= r_count - CW'(1);
                        r_motion    <= t_motion'(r_nkind);
                    end
                end
                S_WAIT: begin
                    if (r_drive == DM_WAIT) begin
                        if (r_wait_left <= {15'd0, r_tick_period}) begin
                            r_wait_left <= '0;
                            r_drive     <= DM_SPEED;
                        end else if (r_wait_left != STAY_FOREVER) begin
                            r_wait_left <= r_wait_left - {15'd0, r_tick_period};
                        end
                    end
                end
                default: begin
                    r_drive <= r_drive;
                end
            endcase

            // output register valid
            if (r_state == S_OUT && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // tick datapath and result payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    r_odo_x    <= s_tdata[31:0];
                    r_odo_y    <= s_tdata[63:32];
                    r_odo_a    <= s_tdata[95:64];
                    r_reached  <= s_tdata[96];
                    r_res_spd  <= 1'b0;
                    r_res_pos  <= 1'b0;
                    r_res_push <= s_tuser && full;
                    r_res_vlin <= '0;
                    r_res_vang <= '0;
                    r_res_dist <= '0;
                    r_res_turn <= '0;
                end
            end
            S_RD_CUR: begin
                r_nx    <= mem_rdata.x;
                r_ny    <= mem_rdata.y;
                r_nhead <= mem_rdata.heading;
                r_nl    <= mem_rdata.spd;
                r_na    <= mem_rdata.trn;
                r_nkind <= mem_rdata.kind;
            end
            S_CAPT: begin
                r_cl    <= mem_rdata.spd;
                r_ca    <= mem_rdata.trn;
                r_cstay <= mem_rdata.stay;
            end
            S_MEAS: begin
                r_ay      <= ady;
                r_turn    <= sat32({da[32], da});
                r_absturn <= (sat32({da[32], da}) == 32'sh8000_0000) ? 32'h8000_0000 :
                             (da[32] ? 32'(-sat32({da[32], da})) : 32'(sat32({da[32], da})));
                r_inang   <= ada <= {15'd0, r_angle_margin};
            end
            S_SQY: begin
                r_a2 <= alu_res;
            end
            S_SQRT: begin
                if (sqsum[64]) begin
                    r_dist <= DIST_MAX;
                end
            end
            S_DIST: begin
                r_dist <= (alu_res[31:0] > {1'b0, DIST_MAX}) ? DIST_MAX : alu_res[30:0];
            end
            S_DECIDE: begin
                r_g   <= tg;
                r_v   <= tv;
                r_c   <= tc;
                r_lim <= tlim;
                r_sgn <= (r_motion == MOT_ROT);
                r_d   <= td;
                r_m   <= tm;
                r_x   <= (r_motion == MOT_ROT) ? r_absturn : {1'b0, r_dist};
                if (inm) begin
                    r_res_pos  <= 1'b1;
                    r_res_dist <= r_dist;
                    r_res_turn <= r_turn;
                end else if (r_motion == MOT_STILL) begin
                    r_res_spd <= 1'b1;
                end else if (r_motion == MOT_CURVE) begin
                    r_res_spd  <= 1'b1;
                    r_res_vlin <= r_lin_speed;
                    r_res_vang <= r_ang_speed;
                end
            end
            S_T2: begin
                r_t1 <= alu_res;
            end
            S_T4: begin
                r_hit <= thit;
            end
            S_RAMP: begin
                r_dneg <= d2[32];
            end
            S_UPD: begin
                r_res_spd <= 1'b1;
                if (r_motion == MOT_LIN) begin
                    r_res_vlin <= sat32(nv);
                end else begin
                    r_res_vang <= sat32(nv);
                end
            end
            S_OUT: begin
                if (out_free) begin
                    r_m_tuser <= {r_res_pos, r_res_spd};
                    r_m_tdata <= {6'd0, r_res_push, r_drive, r_res_turn, r_res_dist,
                                  r_res_vang, r_res_vlin};
                end
            end
            default: begin
                r_t1 <= r_t1;
            end
        endcase
    end

    assign m_tvalid = r_m_valid;
    assign m_tuser  = r_m_tuser;
    assign m_tdata  = r_m_tdata;

    wvp_route_mem #(
        .DEPTH (ROUTE_DEPTH),
        .AW    (AW)
    ) u_route_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    wvp_serial_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_busy  (alu_busy),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    `WVP_ASSERT(a_count_bound, r_count <= CW'(ROUTE_DEPTH))
    `WVP_ASSERT(a_head_bound, r_head <= AW'(ROUTE_DEPTH - 1))
    `WVP_ASSERT_NEXT(a_accept_leaves_idle, s_tvalid && s_tready, r_state != S_IDLE)
    `WVP_ASSERT(a_alu_launch_idle, !(alu_req.start && alu_busy))
    `WVP_ASSERT(a_wait_alu, !(r_state == S_AW) || alu_busy || alu_done)
endmodule
